// ===== rtl/cnaa_pkg.sv =====
`timescale 1ns / 1ps

package cnaa_pkg;

    // fixed field widths of the ports
    localparam int PORT_CH_W    = 16;
    localparam int ROW_W        = 12;
    localparam int COL_W        = 10;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;

    // geometry limits and reset values
    localparam int HEIGHT_LIMIT = 4096;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(1024);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(1024);

    // configuration register map
    typedef enum logic [0:0]
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // result slots of one pixel, in emission order
    localparam int NUM_SLOTS  = 3;
    localparam int SLOT_ABOVE = 0;  // pixel one row up, same column
    localparam int SLOT_LEFT  = 1;  // last row: pixel one column left
    localparam int SLOT_SELF  = 2;  // last row, last column: this pixel

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

endpackage

// ===== rtl/cross_neighbour_antialias_filter.sv =====
`timescale 1ns / 1ps

// a pixel's results go through the pixel stage and then the output register
// throughput: one pixel per cycle while out_stall is low and each pixel causes at most one
//   result; otherwise its results leave one at a time through the single output register,
//   up to two for a last-row pixel and three for the final pixel of a frame
// reset: position counters clear to row 0 column 0, geometry returns to 1024 x 1024;
//   line stores are not cleared and hold no data until a row has been written
module cross_neighbour_antialias_filter
    import cnaa_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int CHANNEL_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    // configuration write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  cfg_reg_t                cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    // pixel input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [PORT_CH_W-1:0]    red_in,
    input  logic [PORT_CH_W-1:0]    green_in,
    input  logic [PORT_CH_W-1:0]    blue_in,

    // result channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [PORT_CH_W-1:0]    red_out,
    output logic [PORT_CH_W-1:0]    green_out,
    output logic [PORT_CH_W-1:0]    blue_out,
    output logic [ROW_W-1:0]        out_row,
    output logic [COL_W-1:0]        out_col,
    output logic                    run_last
);

    // column index and column count widths
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int CB      = CHANNEL_BITS;
    // numerator is at most eight channel values
    localparam int SUM_W   = CB + 3;
    // divide by six as a halving and a reciprocal multiply by one third
    localparam int Y_W     = CB + 2;
    localparam int DIV_K   = CB + 3;
    localparam int DIV3_M  = ((1 << DIV_K) + 2) / 3;
    localparam int PROD_W  = 2 * Y_W;
    localparam logic [Y_W-1:0] DIV3_MUL = Y_W'(DIV3_M);

    typedef logic [2:0][CB-1:0] pix_t;

    // one line store entry: the two rows above the current one at a column
    typedef struct packed
    {
        pix_t older;
        pix_t newer;
    } line_entry_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // register values as used: zero acts as one, large values clamp
    logic [WW-1:0]           w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HEIGHT_REG_W'(1);
        else if (32'(height_reg) > HEIGHT_LIMIT)
            h_eff = HEIGHT_REG_W'(HEIGHT_LIMIT);
        else
            h_eff = height_reg;
    end

    // ------------------------------------------------------------------
    // raster position of the arriving pixel
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    col_reg, col_next;

    logic                    restart;
    logic [ROW_W-1:0]        r_cur;
    logic [CW-1:0]           c_cur;
    logic [WW-1:0]           c_plus;
    logic [HEIGHT_REG_W-1:0] r_plus;
    logic                    last_col;
    logic                    last_row;
    slot_mask_t              mask_new;

    always_comb
    begin
        // counters outside a changed geometry start a new frame
        restart  = (32'(row_reg) >= 32'(h_eff)) || (32'(col_reg) >= 32'(w_eff));
        r_cur    = restart ? '0 : row_reg;
        c_cur    = restart ? '0 : col_reg;
        c_plus   = WW'(c_cur) + WW'(1);
        r_plus   = HEIGHT_REG_W'(r_cur) + HEIGHT_REG_W'(1);
        last_col = (c_plus >= w_eff);
        last_row = (r_plus >= h_eff);

        mask_new            = '0;
        mask_new[SLOT_ABOVE] = (r_cur != '0);
        mask_new[SLOT_LEFT]  = last_row && (c_cur != '0);
        mask_new[SLOT_SELF]  = last_row && last_col;

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : ROW_W'(r_plus);
        end
        else
        begin
            col_next = CW'(c_plus);
            row_next = r_cur;
        end
    end

    // ------------------------------------------------------------------
    // pixel stage: holds one pixel until all its results are sent
    // ------------------------------------------------------------------
    logic        s1_valid_reg, s1_valid_next;
    slot_mask_t  s1_mask_reg, s1_mask_next;
    pix_t        s1_pix_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [CW-1:0]    s1_col_reg;
    logic        s1_r_ge1_reg, s1_r_ge2_reg, s1_c_ge1_reg, s1_c_ge2_reg, s1_right_reg;

    // line store read data with write bypass
    line_entry_t rd0_reg, rd1_reg, byp_reg;
    logic        hit0_reg, hit1_reg;

    // left-hand history of the current row
    pix_t        prev1_reg, prev2_reg, prev_up_reg;

    logic        accept;
    logic        out_can_load;
    logic        load_out;
    logic        s1_done;
    slot_mask_t  sel;
    slot_mask_t  mask_rest;

    line_entry_t eff0;
    pix_t        eff_right;
    line_entry_t wr_data;
    pix_t        pix_in;

    line_entry_t line_mem [MAX_WIDTH];

    assign pix_in[0] = CB'(red_in);
    assign pix_in[1] = CB'(green_in);
    assign pix_in[2] = CB'(blue_in);

    assign eff0      = hit0_reg ? byp_reg : rd0_reg;
    assign eff_right = hit1_reg ? byp_reg.newer : rd1_reg.newer;

    // at the pixel's column the older row takes the newer, the newer takes the pixel
    assign wr_data.older = eff0.newer;
    assign wr_data.newer = s1_pix_reg;

    logic out_valid_reg;

    assign out_can_load = !out_valid_reg || !out_stall;

    // lowest pending slot goes out first
    assign sel       = s1_mask_reg & (~s1_mask_reg + slot_mask_t'(1));
    assign mask_rest = s1_mask_reg & ~sel;

    assign load_out = s1_valid_reg && (s1_mask_reg != '0) && out_can_load;
    assign s1_done  = s1_valid_reg && ((s1_mask_reg == '0) || (load_out && (mask_rest == '0)));
    assign in_stall = s1_valid_reg && !s1_done;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_mask_next  = s1_mask_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_mask_next  = mask_new;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
            s1_mask_next  = '0;
        end
        else if (load_out)
        begin
            s1_mask_next = mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_mask_reg  <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_mask_reg  <= s1_mask_next;
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // payload of the pixel stage and row history, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pix_in;
            s1_row_reg   <= r_cur;
            s1_col_reg   <= c_cur;
            s1_r_ge1_reg <= (r_cur != '0);
            s1_r_ge2_reg <= (r_cur > ROW_W'(1));
            s1_c_ge1_reg <= (c_cur != '0);
            s1_c_ge2_reg <= (c_cur > CW'(1));
            s1_right_reg <= !last_col;

            // the entry being written this cycle is not yet in the memory
            hit0_reg <= s1_valid_reg && (s1_col_reg == c_cur);
            hit1_reg <= s1_valid_reg && (s1_col_reg == CW'(c_cur + CW'(1)));
            byp_reg  <= wr_data;

            prev1_reg   <= s1_pix_reg;
            prev2_reg   <= prev1_reg;
            prev_up_reg <= eff0.newer;
        end
    end

    // line stores: two read ports at the new pixel's column and the next one
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            line_mem[s1_col_reg] <= wr_data;
        if (accept)
        begin
            rd0_reg <= line_mem[c_cur];
            rd1_reg <= line_mem[CW'(c_cur + CW'(1))];
        end
    end

    // ------------------------------------------------------------------
    // operands of the selected result
    // ------------------------------------------------------------------
    pix_t             centre;
    pix_t [3:0]       nb;
    logic [3:0]       nb_ok;
    logic [ROW_W-1:0] res_row;
    logic [CW-1:0]    res_col;

    always_comb
    begin
        nb      = '0;
        nb_ok   = '0;
        centre  = s1_pix_reg;
        res_row = s1_row_reg;
        res_col = s1_col_reg;
        priority if (sel[SLOT_ABOVE])
        begin
            // pixel above: the whole cross is at hand
            centre   = eff0.newer;
            nb[0]    = eff0.older;
            nb_ok[0] = s1_r_ge2_reg;
            nb[1]    = s1_pix_reg;
            nb_ok[1] = 1'b1;
            nb[2]    = prev_up_reg;
            nb_ok[2] = s1_c_ge1_reg;
            nb[3]    = eff_right;
            nb_ok[3] = s1_right_reg;
            res_row  = s1_row_reg - ROW_W'(1);
        end
        else if (sel[SLOT_LEFT])
        begin
            // last row, left pixel: its right neighbour just arrived
            centre   = prev1_reg;
            nb[0]    = prev_up_reg;
            nb_ok[0] = s1_r_ge1_reg;
            nb[1]    = prev2_reg;
            nb_ok[1] = s1_c_ge2_reg;
            nb[2]    = s1_pix_reg;
            nb_ok[2] = 1'b1;
            res_col  = s1_col_reg - CW'(1);
        end
        else
        begin
            // last pixel of the frame: up and left only
            centre   = s1_pix_reg;
            nb[0]    = eff0.newer;
            nb_ok[0] = s1_r_ge1_reg;
            nb[1]    = prev1_reg;
            nb_ok[1] = s1_c_ge1_reg;
        end
    end

    // blend: (centre*count + sum) / (2*count), as a sum of centre+neighbour pairs
    logic [2:0]        nb_count;
    logic [SUM_W-1:0]  num  [3];
    logic [Y_W-1:0]    half [3];
    logic [PROD_W-1:0] prod [3];
    pix_t              blend;

    assign nb_count = 3'(nb_ok[0]) + 3'(nb_ok[1]) + 3'(nb_ok[2]) + 3'(nb_ok[3]);

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            num[ch] = '0;
            for (int k = 0; k < 4; k++)
            begin
                if (nb_ok[k])
                    num[ch] = num[ch] + SUM_W'(centre[ch]) + SUM_W'(nb[k][ch]);
            end
            half[ch] = Y_W'(num[ch] >> 1);
            prod[ch] = PROD_W'(half[ch]) * PROD_W'(DIV3_MUL);

            unique case (nb_count)
                3'd0:    blend[ch] = centre[ch];
                3'd1:    blend[ch] = CB'(num[ch] >> 1);
                3'd2:    blend[ch] = CB'(num[ch] >> 2);
                3'd3:    blend[ch] = CB'(prod[ch] >> DIV_K);
                3'd4:    blend[ch] = CB'(num[ch] >> 3);
                default: blend[ch] = centre[ch];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [PORT_CH_W-1:0] red_out_reg, green_out_reg, blue_out_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [COL_W-1:0]     out_col_reg;
    logic                 run_last_reg;
    logic                 out_valid_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            red_out_reg   <= PORT_CH_W'(blend[0]);
            green_out_reg <= PORT_CH_W'(blend[1]);
            blue_out_reg  <= PORT_CH_W'(blend[2]);
            out_row_reg   <= res_row;
            out_col_reg   <= COL_W'(res_col);
            run_last_reg  <= (mask_rest == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign run_last  = run_last_reg;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

typedef logic [2:0][cnaa_pkg::PORT_CH_W-1:0] rgb_t;

typedef struct {
    rgb_t                       color;
    logic [cnaa_pkg::ROW_W-1:0] row;
    logic [cnaa_pkg::COL_W-1:0] col;
    logic                       last;
} blended_px_t;

class blend_checker;
    localparam int LINE_DEPTH = 1024;

    rgb_t                              older_line [LINE_DEPTH];
    rgb_t                              newer_line [LINE_DEPTH];
    rgb_t                              prev_px;
    rgb_t                              prev2_px;
    int unsigned                       row_pos;
    int unsigned                       col_pos;
    logic [cnaa_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [cnaa_pkg::HEIGHT_REG_W-1:0] height_reg;
    blended_px_t                       expected_q [$];
    int                                errors;

    function new();
        foreach (older_line[i])
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        prev_px    = '0;
        prev2_px   = '0;
        row_pos    = 0;
        col_pos    = 0;
        width_reg  = cnaa_pkg::WIDTH_RESET;
        height_reg = cnaa_pkg::HEIGHT_RESET;
        errors     = 0;
    endfunction

    function void write_reg(cnaa_pkg::cfg_reg_t idx, logic [cnaa_pkg::CFG_DATA_W-1:0] data);
        if (idx == cnaa_pkg::REG_IMAGE_WIDTH)
            width_reg = data[cnaa_pkg::WIDTH_REG_W-1:0];
        else
            height_reg = data;
    endfunction

    // has: up, down, left, right from msb to lsb
    function blended_px_t blend_pixel(rgb_t centre, rgb_t up, rgb_t down, rgb_t left,
                                      rgb_t right, logic [3:0] has,
                                      int unsigned row, int unsigned col);
        blended_px_t     res;
        longint unsigned cnt;
        longint unsigned total;
        longint unsigned quot;
        int              ch;
        cnt = $countones(has);
        for (ch = 0; ch < 3; ch++)
        begin
            total = 0;
            if (has[3]) total += up[ch];
            if (has[2]) total += down[ch];
            if (has[1]) total += left[ch];
            if (has[0]) total += right[ch];
            if (cnt == 0)
                quot = centre[ch];
            else
                quot = (centre[ch] * cnt + total) / (2 * cnt);
            res.color[ch] = quot[cnaa_pkg::PORT_CH_W-1:0];
        end
        res.row  = row[cnaa_pkg::ROW_W-1:0];
        res.col  = col[cnaa_pkg::COL_W-1:0];
        res.last = 1'b0;
        return res;
    endfunction

    // append one predicted result at the tail of the queue
    function void add_expected(blended_px_t px);
        expected_q.insert(expected_q.size(), px);
    endfunction

    function void note_pixel(rgb_t px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned lc;
        int unsigned rc;
        int          first_new;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > cnaa_pkg::HEIGHT_LIMIT) h = cnaa_pkg::HEIGHT_LIMIT;
        if (row_pos >= h || col_pos >= w)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        lc = (c >= 1) ? c - 1 : 0;
        rc = (c + 1 < w) ? c + 1 : c;
        first_new = expected_q.size();

        if (r >= 1)
            add_expected(blend_pixel(newer_line[c], older_line[c], px,
                                     older_line[lc], newer_line[rc],
                                     {r >= 2, 1'b1, c >= 1, c + 1 < w}, r - 1, c));
        older_line[c] = newer_line[c];
        newer_line[c] = px;

        if (r == h - 1)
        begin
            if (c >= 1)
                add_expected(blend_pixel(prev_px, older_line[lc], px, prev2_px, px,
                                         {h >= 2, 1'b0, c >= 2, 1'b1}, r, c - 1));
            if (c == w - 1)
                add_expected(blend_pixel(px, older_line[c], px, prev_px, px,
                                         {h >= 2, 1'b0, c >= 1, 1'b0}, r, c));
        end
        prev2_px = prev_px;
        prev_px  = px;

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;

        if (expected_q.size() > first_new)
            expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v,
                                blended_px_t want);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch at row %0d col %0d, expected %h, actual %h",
                     $time, name, want.row, want.col, want_v, got_v);
            errors++;
        end
    endfunction

    function void check_result(blended_px_t got);
        blended_px_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result at row %0d col %0d, expected none, actual %h",
                     $time, got.row, got.col, got.color);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("red", 16'(want.color[0]), 16'(got.color[0]), want);
        compare_field("green", 16'(want.color[1]), 16'(got.color[1]), want);
        compare_field("blue", 16'(want.color[2]), 16'(got.color[2]), want);
        compare_field("row", 16'(want.row), 16'(got.row), want);
        compare_field("col", 16'(want.col), 16'(got.col), want);
        compare_field("run_last", 16'(want.last), 16'(got.last), want);
    endfunction
endclass

module tb_top;
    import cnaa_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int WATCHDOG_LIMIT = 5000;
    // settle time after the last result, well past the output register latency
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 350;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [PORT_CH_W-1:0]  red_in;
    logic [PORT_CH_W-1:0]  green_in;
    logic [PORT_CH_W-1:0]  blue_in;
    logic                  out_valid;
    logic                  out_stall;
    logic [PORT_CH_W-1:0]  red_out;
    logic [PORT_CH_W-1:0]  green_out;
    logic [PORT_CH_W-1:0]  blue_out;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  run_last;

    blend_checker board;

    // idling mix: sender gaps and receiver stalls in percent
    int src_idle_pct   = 20;
    int sink_stall_pct = 70;
    int random_sent    = 0;
    int quiet_cycles;

    cross_neighbour_antialias_filter uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .out_row   (out_row),
        .out_col   (out_col),
        .run_last  (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result side: check every transfer, then pick the stall for the next cycle
    initial
    begin
        blended_px_t got;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.color = {blue_out, green_out, red_out};
                got.row   = out_row;
                got.col   = out_col;
                got.last  = run_last;
                board.check_result(got);
            end
            out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // watchdog: any transfer on any channel counts as progress
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // half the time a channel extreme, otherwise anything
    function automatic rgb_t random_pixel();
        rgb_t px;
        for (int ch = 0; ch < 3; ch++)
        begin
            case ($urandom_range(3))
                0:       px[ch] = '0;
                1:       px[ch] = '1;
                default: px[ch] = PORT_CH_W'($urandom_range(16'hFFFF));
            endcase
        end
        return px;
    endfunction

    // one pixel transfer, with random idle cycles in front of it
    task automatic send_pixel(input rgb_t px);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= px[0];
        green_in <= px[1];
        blue_in  <= px[2];
        do
            @(posedge clk);
        while (in_stall);
        board.note_pixel(px);
    endtask

    // hold the sender until every pending result has come out
    task automatic drain(input int settle_cycles);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_q.size() != 0);
        repeat (settle_cycles) @(posedge clk);
    endtask

    // both registers back to back while the block is idle; valid stays high between them
    task automatic program_geometry(input logic [CFG_DATA_W-1:0] width_data,
                                    input logic [CFG_DATA_W-1:0] height_data);
        drain(DRAIN_CYCLES);
        cfg_valid <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= width_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(REG_IMAGE_WIDTH, width_data);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= height_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(REG_IMAGE_HEIGHT, height_data);
        cfg_valid <= 1'b0;
    endtask

    // random pixels; the idling mix moves on by thirds of the random part
    task automatic send_frame(input int unsigned n_px);
        for (int unsigned i = 0; i < n_px; i++)
        begin
            send_pixel(random_pixel());
            random_sent++;
            if (random_sent * 3 < RANDOM_ITEMS)
            begin
                src_idle_pct   = 20;
                sink_stall_pct = 70;
            end
            else if (random_sent * 3 < 2 * RANDOM_ITEMS)
            begin
                src_idle_pct   = 70;
                sink_stall_pct = 20;
            end
            else
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            // now and then let the pipeline run dry mid-frame
            if ($urandom_range(49) == 0)
                drain(0);
        end
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned n_px;
        board = new();
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        red_in    <= '0;
        green_in  <= '0;
        blue_in   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // zero registers act as a 1x1 image: the centre passes through
        program_geometry('0, '0);
        send_pixel({16'hFFFF, 16'h0000, 16'hFFFF});
        send_pixel({16'h0000, 16'hFFFF, 16'h0000});

        // 3x3 checkerboard of the extremes, with a mixed centre, hits every neighbour pattern
        program_geometry(CFG_DATA_W'(3), CFG_DATA_W'(3));
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
                send_pixel({16'h0001, 16'h7FFF, 16'h8000});
            else if (i % 2 == 1)
                send_pixel('0);
            else
                send_pixel('1);
        end

        // shrink the width mid-frame so the position restarts at the origin
        program_geometry(CFG_DATA_W'(4), CFG_DATA_W'(3));
        repeat (5) send_pixel(random_pixel());
        program_geometry(CFG_DATA_W'(1), CFG_DATA_W'(3));
        repeat (3) send_pixel(random_pixel());

        // width above the line store size clamps, high bits beyond the register dropped
        program_geometry('1, CFG_DATA_W'(1));
        repeat (4) send_pixel(random_pixel());

        // height above the row limit clamps
        program_geometry(CFG_DATA_W'(1), '1);
        repeat (4) send_pixel(random_pixel());

        // random frames, mostly small, some wide or tall, some cut short
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                0:
                begin
                    w = $urandom_range(40, 9);
                    h = $urandom_range(3, 1);
                end
                1:
                begin
                    w = $urandom_range(3, 1);
                    h = $urandom_range(40, 10);
                end
                default:
                begin
                    w = $urandom_range(8, 1);
                    h = $urandom_range(6, 1);
                end
            endcase
            // a frame left open must restart, so the line stores are never read unwritten
            if (!(board.row_pos == 0 && board.col_pos == 0) &&
                board.row_pos < h && board.col_pos < w)
            begin
                if (board.col_pos >= 1)
                    w = board.col_pos;
                else
                    h = board.row_pos;
            end
            program_geometry({2'($urandom_range(3)), 11'(w)}, CFG_DATA_W'(h));
            n_px = w * h;
            if (n_px > 1 && $urandom_range(99) < 15)
                n_px = $urandom_range(n_px - 1, 1);
            send_frame(n_px);
        end

        drain(DRAIN_CYCLES);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
